### rtl/ptc_pkg.sv
package ptc_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_T_D1, S_T_D2, S_T_V2, S_T_OUT,
    S_P_AA, S_P_B6, S_P_B5, S_P_A3, S_P_A2, S_P_A1, S_P_ZERO,
    S_P_N, S_P_DIVI, S_P_DIV, S_P_DIVF, S_P_S, S_P_Q, S_P_B8, S_P_SUM, S_P_OUT
  } state_t;

  typedef enum logic [1:0] {
    CFG_TEMP = 2'd0, CFG_PRESS_A = 2'd1, CFG_PRESS_B = 2'd2, CFG_PRESS_C = 2'd3
  } cfg_idx_t;

  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_PRESS = 1'b1;
  localparam logic [63:0] T_FINE_OFS = 64'd128000;
  localparam logic [63:0] P_SCALE = 64'd3125;
  localparam logic [20:0] P_FULL = 21'd1048576;
  localparam logic [63:0] P_BIAS = 64'h0000_8000_0000_0000;

  function automatic logic [31:0] sat32(input logic [63:0] u);
    logic [31:0] r;
    r = u[31:0];
    if (u[63] && (u[62:31] != 32'hFFFF_FFFF)) r = 32'h8000_0000;
    if (!u[63] && (u[62:31] != 32'd0)) r = 32'h7FFF_FFFF;
    return r;
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] u, input logic [5:0] n);
    return 64'($signed(u) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

### rtl/pressure_temp_compensation.sv
// Channel | Signals                                   | Dir
// input   | in_valid, in_ready, cmd, raw_reading      | in
// output  | out_valid, out_ready, result_kind, value, | out
//         | divide_by_zero                            |
// config  | cfg_we, cfg_index, cfg_data               | in
// A pressure beat with a zero divisor ends early with divide_by_zero set. Each
// multiply runs as partial products on one shared 32x32 multiplier, the divide as
// a restoring radix-2 loop. One beat is in flight at a time.
// rst clears the calibration words, fine temperature and control state.
// A stalled output holds the last step until out_ready frees the slot.
module pressure_temp_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [19:0] raw_reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] value,
  output logic        divide_by_zero,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ptc_pkg::*;

  state_t state, state_next;
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b;
  logic [15:0] cal_press_c;
  logic [31:0] fine;
  logic [19:0] rraw;
  logic [63:0] rd, ra, rb, rp, rc, rrem, prod;
  logic [5:0]  cnt;
  logic [1:0]  mph;
  logic        qneg;
  logic [63:0] mx, my;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;
  logic        is_mul, out_free, out_load;
  logic [64:0] trial;
  logic [63:0] t1, t2, t3, d1, d2, sp, fine5;

  assign t1 = {48'd0, cal_temp[15:0]};
  assign t2 = sx16(cal_temp[31:16]);
  assign t3 = sx16(cal_temp[47:32]);
  assign d1 = {47'd0, rraw[19:3]} - {47'd0, cal_temp[15:0], 1'b0};
  assign d2 = {48'd0, rraw[19:4]} - t1;
  assign sp = asr(rp, 6'd13);
  assign fine5 = {{32{fine[31]}}, fine} + {{30{fine[31]}}, fine, 2'b00} + 64'd128;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((state == S_T_OUT) || (state == S_P_OUT) ||
                                 ((state == S_P_ZERO) && (ra == 64'd0)));
  assign in_ready = (state == S_IDLE);
  assign trial = {rrem, rb[63]} - {1'b0, ra};

  always_comb begin
    is_mul = 1'b1;
    mx = rd;
    my = rd;
    case (state)
      S_T_D1: begin mx = d1; my = t2; end
      S_T_D2: begin mx = d2; my = d2; end
      S_T_V2: begin mx = ra; my = t3; end
      S_P_AA: begin mx = rd; my = rd; end
      S_P_B6: begin mx = rc; my = sx16(cal_press_b[31:16]); end
      S_P_B5: begin mx = rd; my = sx16(cal_press_b[15:0]); end
      S_P_A3: begin mx = rc; my = sx16(cal_press_a[47:32]); end
      S_P_A2: begin mx = rd; my = sx16(cal_press_a[31:16]); end
      S_P_A1: begin mx = ra; my = {48'd0, cal_press_a[15:0]}; end
      S_P_N: begin
        mx = ({43'd0, P_FULL - {1'b0, rraw}} << 31) - rb;
        my = P_SCALE;
      end
      S_P_S: begin mx = sx16(cal_press_c); my = sp; end
      S_P_Q: begin mx = ra; my = sp; end
      S_P_B8: begin mx = sx16(cal_press_b[63:48]); my = rp; end
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    case (mph)
      2'd1: begin mul_a = mx[31:0]; mul_b = my[63:32]; end
      2'd2: begin mul_a = mx[63:32]; mul_b = my[31:0]; end
      default: begin mul_a = mx[31:0]; mul_b = my[31:0]; end
    endcase
    pp = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = (cmd == CMD_TEMP) ? S_T_D1 : S_P_AA;
      S_T_D1: if (mph == 2'd3) state_next = S_T_D2;
      S_T_D2: if (mph == 2'd3) state_next = S_T_V2;
      S_T_V2: if (mph == 2'd3) state_next = S_T_OUT;
      S_T_OUT: if (out_free) state_next = S_IDLE;
      S_P_AA: if (mph == 2'd3) state_next = S_P_B6;
      S_P_B6: if (mph == 2'd3) state_next = S_P_B5;
      S_P_B5: if (mph == 2'd3) state_next = S_P_A3;
      S_P_A3: if (mph == 2'd3) state_next = S_P_A2;
      S_P_A2: if (mph == 2'd3) state_next = S_P_A1;
      S_P_A1: if (mph == 2'd3) state_next = S_P_ZERO;
      S_P_ZERO: begin
        if (ra != 64'd0) state_next = S_P_N;
        else if (out_free) state_next = S_IDLE;
      end
      S_P_N: if (mph == 2'd3) state_next = S_P_DIVI;
      S_P_DIVI: state_next = S_P_DIV;
      S_P_DIV: if (cnt == 6'd63) state_next = S_P_DIVF;
      S_P_DIVF: state_next = S_P_S;
      S_P_S: if (mph == 2'd3) state_next = S_P_Q;
      S_P_Q: if (mph == 2'd3) state_next = S_P_B8;
      S_P_B8: if (mph == 2'd3) state_next = S_P_SUM;
      S_P_SUM: state_next = S_P_OUT;
      S_P_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mph <= 2'd0;
      cnt <= 6'd0;
      out_valid <= 1'b0;
      fine <= 32'd0;
      cal_temp <= 48'd0;
      cal_press_a <= 64'd0;
      cal_press_b <= 64'd0;
      cal_press_c <= 16'd0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP: cal_temp <= cfg_data[47:0];
          CFG_PRESS_A: cal_press_a <= cfg_data;
          CFG_PRESS_B: cal_press_b <= cfg_data;
          CFG_PRESS_C: cal_press_c <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (is_mul) begin
        mph <= mph + 2'd1;
        if (mph == 2'd0) prod <= pp;
        else if (mph != 2'd3) prod <= prod + {pp[31:0], 32'd0};
      end
      case (state)
        S_IDLE: if (in_valid) begin
          rraw <= raw_reading;
          rd <= {{32{fine[31]}}, fine} - T_FINE_OFS;
        end
        S_T_D1: if (mph == 2'd3) rb <= asr(prod, 6'd11);
        S_T_D2: if (mph == 2'd3) ra <= asr(prod, 6'd12);
        S_T_V2: if (mph == 2'd3) fine <= 32'(rb + asr(prod, 6'd14));
        S_T_OUT: if (out_free) begin
          result_kind <= CMD_TEMP;
          value <= sat32(asr(fine5, 6'd8));
          divide_by_zero <= 1'b0;
        end
        S_P_AA: if (mph == 2'd3) rc <= prod;
        S_P_B6: if (mph == 2'd3) rb <= prod;
        S_P_B5: if (mph == 2'd3)
          rb <= rb + (prod << 17) + (sx16(cal_press_a[63:48]) << 35);
        S_P_A3: if (mph == 2'd3) ra <= asr(prod, 6'd8);
        S_P_A2: if (mph == 2'd3) ra <= ra + (prod << 12) + P_BIAS;
        S_P_A1: if (mph == 2'd3) ra <= asr(prod, 6'd33);
        S_P_ZERO: if (ra == 64'd0 && out_free) begin
          result_kind <= CMD_PRESS;
          value <= 32'd0;
          divide_by_zero <= 1'b1;
        end
        S_P_N: if (mph == 2'd3) rb <= prod;
        S_P_DIVI: begin
          rb <= rb[63] ? -rb : rb;
          ra <= ra[63] ? -ra : ra;
          qneg <= rb[63] ^ ra[63];
          rrem <= 64'd0;
          cnt <= 6'd0;
        end
        S_P_DIV: begin
          cnt <= cnt + 6'd1;
          if (!trial[64]) begin
            rrem <= trial[63:0];
            rb <= {rb[62:0], 1'b1};
          end else begin
            rrem <= {rrem[62:0], rb[63]};
            rb <= {rb[62:0], 1'b0};
          end
        end
        S_P_DIVF: rp <= qneg ? -rb : rb;
        S_P_S: if (mph == 2'd3) ra <= prod;
        S_P_Q: if (mph == 2'd3) ra <= asr(prod, 6'd25);
        S_P_B8: if (mph == 2'd3) rb <= asr(prod, 6'd19);
        S_P_SUM: rp <= asr(rp + ra + rb, 6'd8) + (sx16(cal_press_b[47:32]) << 4);
        S_P_OUT: if (out_free) begin
          result_kind <= CMD_PRESS;
          value <= sat32(rp);
          divide_by_zero <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
